FILE: src/egbw_pkg.sv
// Shared constants of the Exp-Golomb bit writer: operation codes and sizes.
package egbw_pkg;

	// Operation codes carried on the op field
	localparam logic [1:0] OP_FIXED = 2'd0;
	localparam logic [1:0] OP_UE    = 2'd1;
	localparam logic [1:0] OP_SE    = 2'd2;
	localparam logic [1:0] OP_PAD   = 2'd3;

	// Longest fixed field in bits
	localparam int unsigned FIXED_MAX = 8;

	// Pending bits kept between items (always fewer than one byte)
	localparam int unsigned PEND_BITS = 7;

	// Default width limit for the value an Exp-Golomb code can carry
	localparam int unsigned VALUE_BITS_DEF = 32;

endpackage

FILE: src/exp_golomb_bit_writer_core.sv
// MSB-first bitstream writer for fixed fields, ue(v), se(v) and byte padding.
//
// Input channel (in_valid/in_ready): one beat is one syntax element, chosen by
// op: a fixed field of field_bits bits (eight at most) from uvalue, ue(uvalue),
// se(svalue) or zero padding to the next byte boundary. Output channel
// (out_valid/out_ready): one beat per completed byte, first bit in the MSB of
// out_byte; last marks the final byte caused by an input beat. A beat that
// completes no byte produces no output beat; its bits stay pending.
// An input beat is registered into s1 (code value computed on the way in).
// From s1 it merges with the pending bits and loads the byte buffer once the
// buffer is empty or handing out its last byte. The buffer drains one byte per
// cycle while out_ready is high; short header fields run at one beat per cycle
// when the receiver does not stall, and a long code (up to eight bytes) holds
// the next item in s1 until the buffer has drained.
// in_ready stays high while the buffer drains its last byte, so back-to-back
// items see no bubble. When the receiver stalls, the byte buffer holds, s1
// fills and in_ready drops. Reset clears the pending bits and empties s1 and
// the buffer; no output beat is offered until new input arrives.
module exp_golomb_bit_writer_core #(
	parameter int unsigned VALUE_BITS = egbw_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        uvalue,
	input  logic signed [30:0] svalue,
	input  logic [3:0]         field_bits,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last
);

	// Code width, widths of lengths and of the merged word
	localparam int unsigned CW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int unsigned LW    = $clog2(CW + 1);
	localparam int unsigned MAXN  = 2 * CW - 1;
	localparam int unsigned NW    = $clog2(MAXN + 1);
	localparam int unsigned PB    = egbw_pkg::PEND_BITS;
	localparam int unsigned WW    = MAXN + PB;
	localparam int unsigned TW    = $clog2(WW + 1);
	localparam int unsigned NBYTE = WW / 8;
	localparam int unsigned BW    = NBYTE * 8;
	localparam int unsigned CNTW  = $clog2(NBYTE + 1);
	localparam logic [32:0] LIMIT = (33'd1 << CW) - 33'd2;

	logic          s1_v_q;
	logic [1:0]    op_s1;
	logic [CW-1:0] code_s1;
	logic [LW-1:0] flen_s1;

	logic [PB-1:0] pend_q;
	logic [2:0]    pc_q;
	logic [BW-1:0] buf_q;
	logic [CNTW-1:0] cnt_q;

	logic          drain_free;
	logic          fire;

	// Input side: map se, clamp, form the code value
	logic [3:0]    fbc;
	logic [7:0]    fmask;
	logic [31:0]   smag;
	logic [31:0]   smap;
	logic [31:0]   vsel;
	logic [32:0]   vcl;
	logic [32:0]   vinc;
	logic [CW-1:0] code_in;

	always_comb begin
		fbc   = (field_bits > 4'(egbw_pkg::FIXED_MAX)) ? 4'(egbw_pkg::FIXED_MAX) : field_bits;
		fmask = 8'((9'd1 << fbc) - 9'd1);
		smag  = 32'h8000_0000 - {1'b0, $unsigned(svalue)};
		if (svalue[30]) begin
			smap = {smag[30:0], 1'b0};
		end else if (svalue == 31'sd0) begin
			smap = 32'd0;
		end else begin
			smap = {svalue[29:0], 1'b0} - 32'd1;
		end
		vsel = (op == egbw_pkg::OP_SE) ? smap : uvalue;
		vcl  = ({1'b0, vsel} > LIMIT) ? LIMIT : {1'b0, vsel};
		vinc = vcl + 33'd1;
		case (op)
			egbw_pkg::OP_FIXED: code_in = CW'(uvalue[7:0] & fmask);
			egbw_pkg::OP_UE,
			egbw_pkg::OP_SE:    code_in = vinc[CW-1:0];
			default:            code_in = '0;
		endcase
	end

	// Hand-off between s1 and the byte buffer
	assign drain_free = (cnt_q == '0) || ((cnt_q == CNTW'(1)) && out_ready);
	assign fire       = s1_v_q && drain_free;
	assign in_ready   = !s1_v_q || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ready) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			code_s1 <= code_in;
			flen_s1 <= LW'(fbc);
		end
	end

	// Merge: code length, append to pending bits, split off whole bytes
	logic [LW-1:0]   clen;
	logic [NW-1:0]   nadd;
	logic [TW-1:0]   tot;
	logic [2:0]      rem;
	logic [CNTW-1:0] nb;
	logic [WW-1:0]   word_r;
	logic [WW-1:0]   word_l;
	logic [BW-1:0]   buf_new;
	logic [PB-1:0]   pend_new;

	always_comb begin
		clen = '0;
		for (int i = 0; i < CW; i++) begin
			if (code_s1[i]) begin
				clen = LW'(i + 1);
			end
		end
		case (op_s1)
			egbw_pkg::OP_FIXED: nadd = NW'(flen_s1);
			egbw_pkg::OP_UE,
			egbw_pkg::OP_SE:    nadd = NW'({clen, 1'b0}) - NW'(1);
			egbw_pkg::OP_PAD:   nadd = (pc_q == 3'd0) ? '0 : NW'(4'd8 - {1'b0, pc_q});
			default:            nadd = '0;
		endcase
		tot      = TW'(pc_q) + TW'(nadd);
		rem      = tot[2:0];
		nb       = CNTW'(tot >> 3);
		word_r   = (WW'(pend_q) << nadd) | WW'(code_s1);
		word_l   = word_r << (TW'(WW) - tot);
		buf_new  = word_l[WW-1 -: BW];
		pend_new = word_r[PB-1:0] & PB'((8'd1 << rem) - 8'd1);
	end

	// Pending bits advance once per merged item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pc_q   <= '0;
		end else if (fire) begin
			pend_q <= pend_new;
			pc_q   <= rem;
		end
	end

	// Byte buffer: load on merge, advance one byte per output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= nb;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			buf_q <= buf_new;
		end else if (out_valid && out_ready) begin
			buf_q <= buf_q << 8;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_byte  = buf_q[BW-1 -: 8];
	assign last      = (cnt_q == CNTW'(1));

	// Pending register never holds stray bits above the pending count
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q >> pc_q) == '0)
		else $error("pending bits set above pending count");

	// An item that completes no byte leaves nothing to send
	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (nb == '0) |=> !out_valid)
		else $error("output beat offered for an item with no byte");

	// A waiting item in s1 holds its code until merged
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !fire |=> s1_v_q && $stable(code_s1) && $stable(op_s1))
		else $error("s1 item lost or changed while waiting");

	// Draining a non-final byte keeps the run going
	a_drain_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("byte run ended before its last byte");

	// Buffer never holds more bytes than a merge can produce
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> cnt_q <= CNTW'(NBYTE))
		else $error("byte count beyond buffer size");

endmodule

FILE: sim/egbw_stream_checker.sv
// Checker for the Exp-Golomb bit writer: predicts output bytes and compares each beat.
module egbw_stream_checker #(
	parameter int unsigned VALUE_BITS = egbw_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        uvalue,
	input  logic signed [30:0] svalue,
	input  logic [3:0]         field_bits,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         out_byte,
	input  logic               last,
	output int                 fail_count,
	output int                 backlog
);

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} coded_byte_t;

	// Largest ue value whose code value v+1 still fits the value width
	localparam logic [63:0] UE_LIMIT = (VALUE_BITS >= 32) ? 64'hFFFF_FFFE :
		((64'd1 << VALUE_BITS) - 64'd2);

	// Bits not yet forming a byte, right aligned
	logic [6:0]  pend_bits;
	logic [2:0]  pend_cnt;
	coded_byte_t coded_bytes[$];
	int          mismatches = 0;

	// Append n bits MSB first and queue every byte that completes
	function automatic void append_bits(input logic [63:0] bits, input int unsigned n);
		logic [63:0] acc;
		int unsigned cnt;
		acc = ({57'd0, pend_bits} << n) | (bits & ((64'd1 << n) - 64'd1));
		cnt = pend_cnt + n;
		while (cnt >= 8) begin
			cnt = cnt - 8;
			coded_bytes.push_back('{data: acc[cnt +: 8], is_last: 1'b0});
		end
		pend_bits = acc[6:0] & 7'((8'd1 << cnt) - 8'd1);
		pend_cnt  = 3'(cnt);
	endfunction

	// Write ue(v): leading zeros, then v+1 in its natural length
	function automatic void append_ue(input logic [63:0] v);
		logic [63:0] code;
		int unsigned len;
		if (v > UE_LIMIT)
			v = UE_LIMIT;
		code = v + 64'd1;
		len  = 0;
		while (len < 64 && (code >> len) != 64'd0)
			len++;
		append_bits(64'd0, len - 1);
		append_bits(code, len);
	endfunction

	function automatic void encode_element(input logic [1:0] o, input logic [31:0] u,
			input logic [30:0] s, input logic [3:0] n);
		case (o)
		egbw_pkg::OP_FIXED: begin
			append_bits({32'd0, u},
				(n > egbw_pkg::FIXED_MAX) ? egbw_pkg::FIXED_MAX : n);
		end
		egbw_pkg::OP_UE: begin
			append_ue({32'd0, u});
		end
		egbw_pkg::OP_SE: begin
			// positive v goes to 2v-1, zero and negative v to -2v
			if (s[30])
				append_ue((64'h8000_0000 - {33'd0, s}) << 1);
			else if (s == 31'd0)
				append_ue(64'd0);
			else
				append_ue(({33'd0, s} << 1) - 64'd1);
		end
		egbw_pkg::OP_PAD: begin
			if (pend_cnt != 3'd0)
				append_bits(64'd0, 8 - pend_cnt);
		end
		default: begin
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned mark;
		coded_byte_t want;
		if (!arst_n) begin
			pend_bits = '0;
			pend_cnt  = '0;
			coded_bytes.delete();
		end else begin
			// compare each output beat with the oldest expected byte
			if (out_valid && out_ready) begin
				if (coded_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected byte: expected none, actual %02h last %0b",
						$time, out_byte, last);
				end else begin
					want = coded_bytes.pop_front();
					if (out_byte !== want.data) begin
						mismatches++;
						$display("%0t: out_byte mismatch: expected %02h, actual %02h",
							$time, want.data, out_byte);
					end
					if (last !== want.is_last) begin
						mismatches++;
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.is_last, last);
					end
				end
			end
			// predict the bytes an input beat completes; flag the final one
			if (in_valid && in_ready) begin
				mark = coded_bytes.size();
				encode_element(op, uvalue, svalue, field_bits);
				if (coded_bytes.size() > mark) begin
					want = coded_bytes.pop_back();
					want.is_last = 1'b1;
					coded_bytes.push_back(want);
				end
			end
		end
		fail_count <= mismatches;
		backlog    <= coded_bytes.size();
	end

endmodule

FILE: sim/tb_exp_golomb_bit_writer_core.sv
// Testbench top for the Exp-Golomb bit writer: stimulus, handshakes and verdict.
module tb_exp_golomb_bit_writer_core;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [1:0]         op         = egbw_pkg::OP_FIXED;
	logic [31:0]        uvalue     = '0;
	logic signed [30:0] svalue     = '0;
	logic [3:0]         field_bits = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [7:0]         out_byte;
	logic               last;
	logic               calm       = 1'b0;
	int                 fail_count;
	int                 backlog;

	exp_golomb_bit_writer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.uvalue     (uvalue),
		.svalue     (svalue),
		.field_bits (field_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

	egbw_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.uvalue     (uvalue),
		.svalue     (svalue),
		.field_bits (field_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the receiver at random, except during the calm stretch
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 17);
	end

	// Offer one element after a random gap and hold it until the beat is taken
	task automatic send_element(input logic [1:0] o, input logic [31:0] u,
			input logic [30:0] s, input logic [3:0] n);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		uvalue     <= u;
		svalue     <= s;
		field_bits <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random_element();
		logic [1:0]  o;
		logic [31:0] u;
		logic [30:0] s;
		logic [3:0]  n;
		int          sv;
		o = 2'($urandom_range(3));
		n = ($urandom_range(99) < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
		case ($urandom_range(3))
		0: u = $urandom_range(15);
		1: u = $urandom_range(1023);
		2: u = $urandom();
		default: u = 32'hFFFF_FFFF - $urandom_range(3);
		endcase
		case ($urandom_range(2))
		0: begin
			sv = $urandom_range(40);
			sv = sv - 20;
			s  = sv[30:0];
		end
		1: s = 31'($urandom());
		default: begin
			case ($urandom_range(3))
			0: s = 31'h4000_0000;
			1: s = 31'h4000_0001;
			2: s = 31'h3FFF_FFFF;
			default: s = 31'h7FFF_FFFF;
			endcase
		end
		endcase
		send_element(o, u, s, n);
	endtask

	// Drop valid and hold off until every expected byte has come out
	task automatic drain_stream();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every operation, the special cases
		send_element(egbw_pkg::OP_FIXED, 32'd1,         31'd0, 4'd1);
		send_element(egbw_pkg::OP_FIXED, 32'h0000_00A5, 31'd0, 4'd8);
		send_element(egbw_pkg::OP_FIXED, 32'hFFFF_FFFF, 31'd0, 4'd0);
		send_element(egbw_pkg::OP_FIXED, 32'hFFFF_FF3C, 31'd0, 4'd15);
		send_element(egbw_pkg::OP_FIXED, 32'h0000_01FF, 31'd0, 4'd9);
		send_element(egbw_pkg::OP_PAD,   32'd0,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_PAD,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 4'd15);
		send_element(egbw_pkg::OP_UE,    32'd0,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_UE,    32'd1,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_UE,    32'hFFFF_FFFE, 31'd0, 4'd0);
		send_element(egbw_pkg::OP_UE,    32'hFFFF_FFFF, 31'd0, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'd1, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'h7FFF_FFFF, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'h3FFF_FFFF, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'h4000_0001, 4'd0);
		send_element(egbw_pkg::OP_SE,    32'd0,         31'h4000_0000, 4'd0);
		send_element(egbw_pkg::OP_FIXED, 32'd5,         31'd0, 4'd3);
		send_element(egbw_pkg::OP_UE,    32'd6,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_PAD,   32'd0,         31'd0, 4'd0);
		send_element(egbw_pkg::OP_FIXED, 32'h0000_007F, 31'd0, 4'd7);
		send_element(egbw_pkg::OP_FIXED, 32'd0,         31'd0, 4'd7);
		send_element(egbw_pkg::OP_PAD,   32'd0,         31'd0, 4'd0);
		drain_stream();

		// random: calm stretch in the middle, one more full drain
		for (int i = 0; i < 180; i++) begin
			calm <= (i >= 60 && i < 110);
			if (i == 120)
				drain_stream();
			send_random_element();
		end

		drain_stream();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_exp_golomb_bit_writer_core: done, clean");
		else
			$display("tb_exp_golomb_bit_writer_core: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb_exp_golomb_bit_writer_core: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/egbw_pkg.sv
src/exp_golomb_bit_writer_core.sv
sim/egbw_stream_checker.sv
sim/tb_exp_golomb_bit_writer_core.sv
